// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define TGU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define TGU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tgu_pkg.sv -----
`default_nettype none
package tgu_pkg;

    localparam int COARSE_POINTS = 4096;
    localparam int MAX_FINE_AXIS = 1024;
    localparam int ADDR_W        = 12;
    localparam int Q_W           = 10;
    localparam int FAC_W         = 7;
    localparam int SIZE_W        = 11;
    localparam int FRAC_W        = 16;
    localparam int W_W           = FRAC_W + 1;
    localparam int DIV_W         = Q_W + FRAC_W;
    localparam int VAL_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int MAX_STEPS     = 8;

    // Divider steps done by each of the four front stages; they add up to DIV_W.
    localparam int unsigned DIV_STEPS [4] = '{7, 7, 6, 6};

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_SIZE_Z = 3'd5;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [ADDR_W-1:0]       coarse_addr;
        logic signed [VAL_W-1:0] coarse_value;
        logic [Q_W-1:0]          query_x;
        logic [Q_W-1:0]          query_y;
        logic [Q_W-1:0]          query_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] fine_value;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic [FAC_W-1:0] rem;
        logic [DIV_W-1:0] sh;
    } t_div;

    // One restoring division step: the quotient bit enters at the bottom of sh.
    function automatic t_div div_step(t_div d, logic [FAC_W-1:0] fac);
        logic [FAC_W:0] t;
        t_div o;
        t = {d.rem, d.sh[DIV_W-1]};
        o.sh = {d.sh[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, fac}) begin
            t = t - {1'b0, fac};
            o.sh[0] = 1'b1;
        end
        o.rem = t[FAC_W-1:0];
        return o;
    endfunction

    function automatic t_div div_run(t_div d, logic [FAC_W-1:0] fac, int unsigned n);
        t_div r;
        r = d;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if (i < n) begin
                r = div_step(r, fac);
            end
        end
        return r;
    endfunction

    // (b - a) * f, the fractional part of a linear blend.
    function automatic logic signed [50:0] lerp_prod(logic signed [VAL_W-1:0] a,
                                                     logic signed [VAL_W-1:0] b,
                                                     logic [W_W-1:0] f);
        logic signed [VAL_W:0] d;
        d = 33'(b) - 33'(a);
        return d * $signed({1'b0, f});
    endfunction

    // a + round(p / 65536), rounding half up; the result stays within 32 bits.
    function automatic logic signed [VAL_W-1:0] lerp_round(logic signed [VAL_W-1:0] a,
                                                           logic signed [50:0] p);
        logic signed [50:0] s;
        s = (p + 51'sd32768) >>> FRAC_W;
        return a + s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/tgu_in_if.sv -----
`default_nettype none
interface tgu_in_if;
    logic              valid;
    logic              ready;
    tgu_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/tgu_out_if.sv -----
`default_nettype none
interface tgu_out_if;
    logic               valid;
    logic               ready;
    tgu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/trilinear_grid_upsampler_top.sv -----
`default_nettype none
// Channel   Direction  Handshake     Payload
// i_req     in         valid/ready   cmd, coarse_addr, coarse_value, query_x/y/z
// o_rsp     out        valid/ready   fine_value, saturated
// i_cfg_*   in         write enable  register index, 11-bit write data
//
// A write request takes a single memory-port access; a query reads its eight
// neighbors through the single port before the fetch unit takes the next request.
// A query passes 7 front stages, the fetch register, 8 reads and 8 blend stages.
// Synchronous active-low reset clears control state; grid memory is not cleared.
// A stall at o_rsp backs up through the pipeline without losing or repeating requests.
module trilinear_grid_upsampler_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tgu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tgu_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    tgu_in_if.sink                          i_req,
    tgu_out_if.source                       o_rsp
);
    import tgu_pkg::*;

    typedef struct packed {
        logic [2:0][Q_W-1:0] b;
        logic [2:0][W_W-1:0] f;
        logic [SIZE_W-1:0]   nx;
        logic [SIZE_W-1:0]   ny;
        logic [ADDR_W-1:0]   t;
        logic [ADDR_W-1:0]   nxny;
        logic [ADDR_W-1:0]   u;
    } t_geo;

    // Configuration.
    logic [FAC_W-1:0]  r_fac  [3];
    logic [SIZE_W-1:0] r_fine [3];
    logic [FAC_W-1:0]  w_fac  [3];
    logic [SIZE_W-1:0] w_size [3];
    logic [FAC_W-1:0]  w_lfac [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_fac[a]  <= FAC_W'(1);
                r_fine[a] <= SIZE_W'(16);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FACTOR_X:    r_fac[0]  <= i_cfg_wdata[FAC_W-1:0];
                REG_FACTOR_Y:    r_fac[1]  <= i_cfg_wdata[FAC_W-1:0];
                REG_FACTOR_Z:    r_fac[2]  <= i_cfg_wdata[FAC_W-1:0];
                REG_FINE_SIZE_X: r_fine[0] <= i_cfg_wdata;
                REG_FINE_SIZE_Y: r_fine[1] <= i_cfg_wdata;
                REG_FINE_SIZE_Z: r_fine[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_fac[a]  = (r_fac[a] == '0) ? FAC_W'(1) : r_fac[a];
            w_size[a] = (r_fine[a] > SIZE_W'(MAX_FINE_AXIS)) ? SIZE_W'(MAX_FINE_AXIS)
                                                             : r_fine[a];
        end
        for (int l = 0; l < 6; l++) begin
            w_lfac[l] = w_fac[l % 3];
        end
    end

    // Front pipeline: stages 1-4 divide, 5 clamps the last cell, 6-7 form the address.
    logic           r_pv [1:7];
    logic           fe   [1:7];
    t_in_item       r_s_item [1:7];
    t_div [5:0]     r_s_div  [1:4];
    t_div [5:0]     n_div    [1:4];
    t_geo           r_geo    [5:7];
    t_geo           n_geo5;
    t_geo           n_geo6;
    t_geo           n_geo7;
    logic [Q_W-1:0] w_q [3];
    t_div           w_init;
    logic [SIZE_W-1:0] w_nq, w_n, w_nm2;
    logic [DIV_W-1:0]  w_quo;
    logic [20:0]       w_m_t;
    logic [21:0]       w_m_nn;
    logic [ADDR_W-1:0] w_yt;
    logic [22:0]       w_m_u;

    assign w_q[0] = i_req.data.query_x;
    assign w_q[1] = i_req.data.query_y;
    assign w_q[2] = i_req.data.query_z;

    always_comb begin
        w_init = '0;
        for (int l = 0; l < 6; l++) begin
            w_init.rem = '0;
            if (l < 3) begin
                w_init.sh = {w_q[l % 3], {FRAC_W{1'b0}}};
            end else begin
                w_init.sh = DIV_W'(w_size[l % 3]);
            end
            n_div[1][l] = div_run(w_init, w_lfac[l], DIV_STEPS[0]);
            n_div[2][l] = div_run(r_s_div[1][l], w_lfac[l], DIV_STEPS[1]);
            n_div[3][l] = div_run(r_s_div[2][l], w_lfac[l], DIV_STEPS[2]);
            n_div[4][l] = div_run(r_s_div[3][l], w_lfac[l], DIV_STEPS[3]);
        end
    end

    // Last-cell rule per axis; the coarse size never drops below two.
    always_comb begin
        n_geo5 = '0;
        w_nq = '0;
        w_n = '0;
        w_nm2 = '0;
        w_quo = '0;
        for (int a = 0; a < 3; a++) begin
            w_quo = r_s_div[4][a].sh;
            w_nq  = r_s_div[4][a + 3].sh[SIZE_W-1:0];
            w_n   = (w_nq < SIZE_W'(2)) ? SIZE_W'(2) : w_nq;
            w_nm2 = w_n - SIZE_W'(2);
            if ({1'b0, w_quo[DIV_W-1:FRAC_W]} >= w_n - SIZE_W'(1)) begin
                n_geo5.b[a] = w_nm2[Q_W-1:0];
                n_geo5.f[a] = W_W'(1) << FRAC_W;
            end else begin
                n_geo5.b[a] = w_quo[DIV_W-1:FRAC_W];
                n_geo5.f[a] = {1'b0, w_quo[FRAC_W-1:0]};
            end
            if (a == 0) begin
                n_geo5.nx = w_n;
            end else if (a == 1) begin
                n_geo5.ny = w_n;
            end
        end
    end

    assign w_m_t  = r_geo[5].ny * r_geo[5].b[2];
    assign w_m_nn = r_geo[5].nx * r_geo[5].ny;
    assign w_yt   = {2'b00, r_geo[6].b[1]} + r_geo[6].t;
    assign w_m_u  = r_geo[6].nx * w_yt;

    always_comb begin
        n_geo6      = r_geo[5];
        n_geo6.t    = w_m_t[ADDR_W-1:0];
        n_geo6.nxny = w_m_nn[ADDR_W-1:0];
        n_geo7      = r_geo[6];
        n_geo7.u    = w_m_u[ADDR_W-1:0];
    end

    // Fetch unit and gather registers.
    logic              r_fv;
    t_in_item          r_f_item;
    logic [ADDR_W-1:0] r_f_a0, r_f_nx, r_f_nxny;
    logic [2:0][W_W-1:0] r_f_w;
    logic [2:0]        r_fcnt;
    logic              r_rv;
    logic [2:0]        r_ridx;
    logic signed [VAL_W-1:0] r_c [0:6];
    logic [2:0][W_W-1:0] r_g_w;
    logic [VAL_W-1:0]  r_mem [0:COARSE_POINTS-1];
    logic signed [VAL_W-1:0] r_mq;

    logic              w_hold, w_f_is_q, w_f_act, w_rd_en, w_wr_en, w_f_done, w_f_en, w_gx;
    logic [ADDR_W-1:0] w_rd_addr, w_m_addr;
    logic              be [1:8];

    always_comb begin
        w_hold    = r_rv && (r_ridx == 3'd7) && !be[1];
        w_f_is_q  = (r_f_item.cmd == CMD_QUERY);
        w_f_act   = r_fv && !w_hold;
        w_rd_en   = w_f_act && w_f_is_q;
        w_wr_en   = w_f_act && !w_f_is_q;
        w_f_done  = w_f_act && (!w_f_is_q || (r_fcnt == 3'd7));
        w_f_en    = !r_fv || w_f_done;
        w_gx      = r_rv && (r_ridx == 3'd7) && be[1];
        // Neighbor order: bit 0 steps x, bit 1 steps y, bit 2 steps z.
        w_rd_addr = r_f_a0 + (r_fcnt[0] ? ADDR_W'(1) : '0)
                           + (r_fcnt[1] ? r_f_nx : '0)
                           + (r_fcnt[2] ? r_f_nxny : '0);
        w_m_addr  = w_f_is_q ? w_rd_addr : r_f_item.coarse_addr;
    end

    always_comb begin
        fe[7] = !r_pv[7] || w_f_en;
        for (int s = 6; s >= 1; s--) begin
            fe[s] = !r_pv[s] || fe[s + 1];
        end
    end

    assign i_req.ready = fe[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 7; s++) begin
                r_pv[s] <= 1'b0;
            end
        end else begin
            if (fe[1]) begin
                r_pv[1] <= i_req.valid;
            end
            for (int s = 2; s <= 7; s++) begin
                if (fe[s]) begin
                    r_pv[s] <= r_pv[s - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe[1]) begin
            r_s_item[1] <= i_req.data;
            r_s_div[1]  <= n_div[1];
        end
        for (int s = 2; s <= 4; s++) begin
            if (fe[s]) begin
                r_s_item[s] <= r_s_item[s - 1];
                r_s_div[s]  <= n_div[s];
            end
        end
        if (fe[5]) begin
            r_s_item[5] <= r_s_item[4];
            r_geo[5]    <= n_geo5;
        end
        if (fe[6]) begin
            r_s_item[6] <= r_s_item[5];
            r_geo[6]    <= n_geo6;
        end
        if (fe[7]) begin
            r_s_item[7] <= r_s_item[6];
            r_geo[7]    <= n_geo7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= 1'b0;
            r_fcnt <= '0;
            r_rv   <= 1'b0;
        end else begin
            if (w_f_en) begin
                r_fv <= r_pv[7];
            end
            if (w_rd_en) begin
                r_fcnt <= r_fcnt + 3'd1;
            end
            if (!w_hold) begin
                r_rv <= w_rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_en) begin
            r_f_item <= r_s_item[7];
            r_f_a0   <= {2'b00, r_geo[7].b[0]} + r_geo[7].u;
            r_f_nx   <= ADDR_W'(r_geo[7].nx);
            r_f_nxny <= r_geo[7].nxny;
            r_f_w    <= r_geo[7].f;
        end
        if (w_rd_en) begin
            r_ridx <= r_fcnt;
        end
        if (w_rd_en && (r_fcnt == 3'd7)) begin
            r_g_w <= r_f_w;
        end
        if (r_rv && (r_ridx != 3'd7)) begin
            r_c[r_ridx] <= r_mq;
        end
    end

    // Single-port grid memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_m_addr] <= r_f_item.coarse_value;
        end else if (w_rd_en) begin
            r_mq <= r_mem[w_m_addr];
        end
    end

    // Blend pipeline: product and rounding stages for x, y and z, then scale and clip.
    logic                    r_bv [1:8];
    logic [2:0][W_W-1:0]     r_bw [1:4];
    logic signed [VAL_W-1:0] r1_a [0:3];
    logic signed [50:0]      r1_p [0:3];
    logic signed [VAL_W-1:0] r2_v [0:3];
    logic signed [VAL_W-1:0] r3_a [0:1];
    logic signed [50:0]      r3_p [0:1];
    logic signed [VAL_W-1:0] r4_v [0:1];
    logic signed [VAL_W-1:0] r5_a;
    logic signed [50:0]      r5_p;
    logic signed [VAL_W-1:0] r6_v;
    logic signed [39:0]      r7_m;
    t_out_item               r_out;
    logic signed [VAL_W-1:0] w_cv [0:7];

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            w_cv[k] = r_c[k];
        end
        w_cv[7] = r_mq;
    end

    always_comb begin
        be[8] = !r_bv[8] || o_rsp.ready;
        for (int s = 7; s >= 1; s--) begin
            be[s] = !r_bv[s] || be[s + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 8; s++) begin
                r_bv[s] <= 1'b0;
            end
        end else begin
            if (be[1]) begin
                r_bv[1] <= w_gx;
            end
            for (int s = 2; s <= 8; s++) begin
                if (be[s]) begin
                    r_bv[s] <= r_bv[s - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (be[1]) begin
            r_bw[1] <= r_g_w;
            for (int k = 0; k < 4; k++) begin
                r1_a[k] <= w_cv[2 * k];
                r1_p[k] <= lerp_prod(w_cv[2 * k], w_cv[2 * k + 1], r_g_w[0]);
            end
        end
        if (be[2]) begin
            r_bw[2] <= r_bw[1];
            for (int k = 0; k < 4; k++) begin
                r2_v[k] <= lerp_round(r1_a[k], r1_p[k]);
            end
        end
        if (be[3]) begin
            r_bw[3] <= r_bw[2];
            for (int k = 0; k < 2; k++) begin
                r3_a[k] <= r2_v[2 * k];
                r3_p[k] <= lerp_prod(r2_v[2 * k], r2_v[2 * k + 1], r_bw[2][1]);
            end
        end
        if (be[4]) begin
            r_bw[4] <= r_bw[3];
            for (int k = 0; k < 2; k++) begin
                r4_v[k] <= lerp_round(r3_a[k], r3_p[k]);
            end
        end
        if (be[5]) begin
            r5_a <= r4_v[0];
            r5_p <= lerp_prod(r4_v[0], r4_v[1], r_bw[4][2]);
        end
        if (be[6]) begin
            r6_v <= lerp_round(r5_a, r5_p);
        end
        if (be[7]) begin
            r7_m <= r6_v * $signed({1'b0, w_fac[0]});
        end
        if (be[8]) begin
            if (r7_m > 40'sh007FFFFFFF) begin
                r_out.fine_value <= 32'sh7FFFFFFF;
                r_out.saturated  <= 1'b1;
            end else if (r7_m < -40'sh0080000000) begin
                r_out.fine_value <= 32'sh80000000;
                r_out.saturated  <= 1'b1;
            end else begin
                r_out.fine_value <= r7_m[VAL_W-1:0];
                r_out.saturated  <= 1'b0;
            end
        end
    end

    assign o_rsp.valid = r_bv[8];
    assign o_rsp.data  = r_out;

`include "assert_macros.svh"

    `TGU_ASSERT_NEXT(a_hold_keeps_read, i_clk, i_rst_n, w_hold, $stable(r_mq), "read data changed while the last neighbor waited")
    `TGU_ASSERT_IMPLY(a_count_only_query, i_clk, i_rst_n, r_fcnt != 3'd0, r_fv && (r_f_item.cmd == CMD_QUERY), "neighbor count running without a query")
    `TGU_ASSERT_IMPLY(a_blend_from_gather, i_clk, i_rst_n, $rose(r_bv[1]), $past(r_rv && (r_ridx == 3'd7)), "blend stage filled without a completed gather")

endmodule
`default_nettype wire
